/* design/lbi_pkg.sv */
package lbi_pkg;

  // Operation codes of an input word
  typedef logic [2:0] op_t;
  localparam op_t OP_TICK      = 3'd0;
  localparam op_t OP_LED_ON    = 3'd1;
  localparam op_t OP_LED_OFF   = 3'd2;
  localparam op_t OP_TOGGLE    = 3'd3;
  localparam op_t OP_AUTO      = 3'd4;
  localparam op_t OP_CMD_ERR   = 3'd5;
  localparam op_t OP_PARAM_ERR = 3'd6;

  // Error codes
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE  = 2'd0;
  localparam err_t ERR_CMD   = 2'd1;
  localparam err_t ERR_PARAM = 2'd2;

  // Configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POLL_EN     = 3'd0;
  localparam cfg_idx_t CFG_PERIOD_STEP = 3'd1;
  localparam cfg_idx_t CFG_CLICK_WIN   = 3'd2;
  localparam cfg_idx_t CFG_HB_INTERVAL = 3'd3;
  localparam cfg_idx_t CFG_ERR_HOLD    = 3'd4;
  localparam cfg_idx_t CFG_PULSE_SPACE = 3'd5;

  localparam int CFG_DATA_W = 16;

  // Heartbeat phases
  typedef logic [2:0] hb_phase_t;
  localparam hb_phase_t HB_IDLE   = 3'd0;
  localparam hb_phase_t HB_START  = 3'd1;
  localparam hb_phase_t HB_FIRST  = 3'd2;
  localparam hb_phase_t HB_GAP    = 3'd3;
  localparam hb_phase_t HB_SECOND = 3'd4;

  typedef struct packed {
    logic        poll_en;
    logic [9:0]  period_step;
    logic [11:0] click_window;
    logic [15:0] hb_interval;
    logic [15:0] error_hold;
    logic [9:0]  pulse_spacing;
  } cfg_t;

  typedef struct packed {
    logic        led_level;
    logic [15:0] blink_period;
    err_t        error_code;
    logic        auto_mode;
  } result_t;

  localparam logic [15:0] PERIOD_RESET = 16'd500;
  localparam logic [15:0] PERIOD_MAX   = 16'hFFFF;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;

endpackage

/* design/lbi_if.sv */
interface lbi_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic       button_level;

  modport source (output valid, output operation, output button_level, input ready);
  modport sink   (input valid, input operation, input button_level, output ready);
endinterface

interface lbi_out_if;
  logic        valid;
  logic        ready;
  logic        led_level;
  logic [15:0] blink_period;
  logic [1:0]  error_code;
  logic        auto_mode;

  modport source (output valid, output led_level, output blink_period,
                  output error_code, output auto_mode, input ready);
  modport sink   (input valid, input led_level, input blink_period,
                  input error_code, input auto_mode, output ready);
endinterface

/* design/lbi_cfg_regs.sv */
module lbi_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                we,
  input  lbi_pkg::cfg_idx_t                   index,
  input  logic [lbi_pkg::CFG_DATA_W-1:0]      wdata,
  output lbi_pkg::cfg_t                       cfg
);
  import lbi_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_en       <= 1'b1;
      cfg_r.period_step   <= 10'd100;
      cfg_r.click_window  <= 12'd400;
      cfg_r.hb_interval   <= 16'd2200;
      cfg_r.error_hold    <= 16'd1000;
      cfg_r.pulse_spacing <= 10'd50;
    end else if (we) begin
      unique case (index)
        CFG_POLL_EN:     cfg_r.poll_en       <= wdata[0];
        CFG_PERIOD_STEP: cfg_r.period_step   <= wdata[9:0];
        CFG_CLICK_WIN:   cfg_r.click_window  <= wdata[11:0];
        CFG_HB_INTERVAL: cfg_r.hb_interval   <= wdata[15:0];
        CFG_ERR_HOLD:    cfg_r.error_hold    <= wdata[15:0];
        CFG_PULSE_SPACE: cfg_r.pulse_spacing <= wdata[9:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/lbi_core.sv */
module lbi_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lbi_pkg::op_t     op,
  input  logic             level,
  input  lbi_pkg::cfg_t    cfg,
  output lbi_pkg::result_t res
);
  import lbi_pkg::*;

  logic [31:0] time_r, time_nxt;
  logic [31:0] toggle_stamp_r, toggle_stamp_nxt;
  logic [31:0] hb_stamp_r, hb_stamp_nxt;
  hb_phase_t   hb_phase_r, hb_phase_nxt;
  logic [31:0] err_stamp_r, err_stamp_nxt;
  logic [31:0] press_stamp_r, press_stamp_nxt;
  logic [7:0]  press_count_r, press_count_nxt;
  logic        prev_btn_r, prev_btn_nxt;
  logic        auto_r, auto_nxt;
  logic        led_r, led_nxt;
  logic [15:0] period_r, period_nxt;
  err_t        err_r, err_nxt;

  logic [31:0] now;
  logic [31:0] hb_elapsed;
  logic [31:0] space1, space2, space3;
  logic [16:0] period_sum;

  assign now    = time_r + 32'd1;
  assign space1 = {22'd0, cfg.pulse_spacing};
  assign space2 = {21'd0, cfg.pulse_spacing, 1'b0};
  assign space3 = space1 + space2;

  always_comb begin
    time_nxt         = time_r;
    toggle_stamp_nxt = toggle_stamp_r;
    hb_stamp_nxt     = hb_stamp_r;
    hb_phase_nxt     = hb_phase_r;
    err_stamp_nxt    = err_stamp_r;
    press_stamp_nxt  = press_stamp_r;
    press_count_nxt  = press_count_r;
    prev_btn_nxt     = prev_btn_r;
    auto_nxt         = auto_r;
    led_nxt          = led_r;
    period_nxt       = period_r;
    err_nxt          = err_r;
    hb_elapsed       = 32'd0;
    period_sum       = 17'd0;

    case (op)
      OP_TICK: begin
        time_nxt = now;
        if (auto_r) begin
          // blink or steady error display
          if (err_r == ERR_CMD) begin
            led_nxt = 1'b1;
          end else if (err_r == ERR_PARAM) begin
            led_nxt = 1'b0;
          end else if ((now - toggle_stamp_r) >= {16'd0, period_r}) begin
            toggle_stamp_nxt = now;
            led_nxt          = ~led_r;
          end
          // heartbeat restart, then double flash
          if ((now - hb_stamp_r) >= {16'd0, cfg.hb_interval}) begin
            hb_stamp_nxt = now;
            hb_phase_nxt = HB_START;
          end
          hb_elapsed = now - hb_stamp_nxt;
          case (hb_phase_nxt)
            HB_START: begin
              led_nxt      = 1'b1;
              hb_phase_nxt = HB_FIRST;
            end
            HB_FIRST: if (hb_elapsed > space1) begin
              led_nxt      = 1'b0;
              hb_phase_nxt = HB_GAP;
            end
            HB_GAP: if (hb_elapsed > space2) begin
              led_nxt      = 1'b1;
              hb_phase_nxt = HB_SECOND;
            end
            HB_SECOND: if (hb_elapsed > space3) begin
              led_nxt      = 1'b0;
              hb_phase_nxt = HB_IDLE;
            end
            default: ;
          endcase
        end
        // periodic error clear
        if ((now - err_stamp_r) >= {16'd0, cfg.error_hold}) begin
          err_stamp_nxt = now;
          err_nxt       = ERR_NONE;
        end
        // button clicks
        if (cfg.poll_en) begin
          if (!level && prev_btn_r) begin
            if (press_count_r != COUNT_MAX) press_count_nxt = press_count_r + 8'd1;
            press_stamp_nxt = now;
          end
          prev_btn_nxt = level;
          if (press_count_nxt != 8'd0 &&
              (now - press_stamp_nxt) > {20'd0, cfg.click_window}) begin
            period_sum = {1'b0, period_r} + {7'd0, cfg.period_step};
            if (press_count_nxt == 8'd1) begin
              if (period_r > {6'd0, cfg.period_step})
                period_nxt = period_r - {6'd0, cfg.period_step};
            end else begin
              period_nxt = period_sum[16] ? PERIOD_MAX : period_sum[15:0];
            end
            press_count_nxt = 8'd0;
          end
        end
      end
      OP_LED_ON: begin
        auto_nxt = 1'b0; hb_phase_nxt = HB_IDLE; led_nxt = 1'b1;
      end
      OP_LED_OFF: begin
        auto_nxt = 1'b0; hb_phase_nxt = HB_IDLE; led_nxt = 1'b0;
      end
      OP_TOGGLE: begin
        auto_nxt = 1'b0; hb_phase_nxt = HB_IDLE; led_nxt = ~led_r;
      end
      OP_AUTO:      auto_nxt = 1'b1;
      OP_CMD_ERR:   err_nxt  = ERR_CMD;
      OP_PARAM_ERR: err_nxt  = ERR_PARAM;
      default: ;  // unused code: report state as is
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r         <= 32'd0;
      toggle_stamp_r <= 32'd0;
      hb_stamp_r     <= 32'd0;
      hb_phase_r     <= HB_IDLE;
      err_stamp_r    <= 32'd0;
      press_stamp_r  <= 32'd0;
      press_count_r  <= 8'd0;
      prev_btn_r     <= 1'b1;
      auto_r         <= 1'b1;
      led_r          <= 1'b0;
      period_r       <= PERIOD_RESET;
      err_r          <= ERR_NONE;
    end else if (fire) begin
      time_r         <= time_nxt;
      toggle_stamp_r <= toggle_stamp_nxt;
      hb_stamp_r     <= hb_stamp_nxt;
      hb_phase_r     <= hb_phase_nxt;
      err_stamp_r    <= err_stamp_nxt;
      press_stamp_r  <= press_stamp_nxt;
      press_count_r  <= press_count_nxt;
      prev_btn_r     <= prev_btn_nxt;
      auto_r         <= auto_nxt;
      led_r          <= led_nxt;
      period_r       <= period_nxt;
      err_r          <= err_nxt;
    end
  end

  assign res.led_level    = led_nxt;
  assign res.blink_period = period_nxt;
  assign res.error_code   = err_nxt;
  assign res.auto_mode    = auto_nxt;

endmodule

/* design/led_button_indicator_top.sv */
// An accepted word waits in the input register, then goes on to the result register.
// While results are taken, one word per cycle, set by the single update pass of lbi_core
// between the input register and the result register.
// The input side stays ready while a result word waits, as long as the input
// register is empty or moves on in the same cycle.
// Reset (rst_n low, synchronous) empties both registers and loads state and
// configuration with their power-on values; no clearing pass is needed.
module led_button_indicator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  lbi_in_if.sink                         in_ch,
  lbi_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  lbi_pkg::cfg_idx_t              cfg_index,
  input  logic [lbi_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lbi_pkg::*;

  cfg_t    cfg;
  result_t res;

  // input register
  logic    in_valid_r;
  op_t     op_r;
  logic    level_r;

  // result register
  logic    out_valid_r;
  result_t out_r;

  logic    advance;   // result register free to take a word this cycle
  logic    fire;      // held input word is processed this cycle
  logic    in_take;

  assign advance   = !out_valid_r || out_ch.ready;
  assign fire      = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take   = in_ch.valid && in_ch.ready;

  lbi_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  lbi_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .op    (op_r),
    .level (level_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Hold the input word until the update pass takes it; refill in the same
  // cycle when a new word arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r    <= in_ch.operation;
      level_r <= in_ch.button_level;
    end
  end

  // Result register: load on every processed word, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.led_level    = out_r.led_level;
  assign out_ch.blink_period = out_r.blink_period;
  assign out_ch.error_code   = out_r.error_code;
  assign out_ch.auto_mode    = out_r.auto_mode;

endmodule

/* design/lbi_checker.sv */
module lbi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        led_level,
  input logic [15:0] blink_period,
  input logic [1:0]  error_code,
  input logic        auto_mode
);
  import lbi_pkg::*;

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(led_level) &&
      $stable(blink_period) && $stable(error_code) && $stable(auto_mode))
    else $error("stalled result word changed");

  // only defined error codes appear
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (error_code == ERR_NONE || error_code == ERR_CMD ||
                   error_code == ERR_PARAM))
    else $error("undefined error code");

  // the blink period never drops to zero
  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> blink_period != 16'd0)
    else $error("blink period reached zero");

  // a new result word needs an earlier accepted input word
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) && $past(rst_n, 2) |->
      $past(in_valid && in_ready, 2))
    else $error("result word without input word");

endmodule

bind led_button_indicator_top lbi_checker u_lbi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .led_level    (out_ch.led_level),
  .blink_period (out_ch.blink_period),
  .error_code   (out_ch.error_code),
  .auto_mode    (out_ch.auto_mode)
);
